// ----- sv/hrp_pkg.sv -----
// hrp_pkg: shared types, codes and character lookups for the request head parser
// no dependencies; imported by every module of the parser
package hrp_pkg;

	// width of the parsed length and of the body counter
	localparam int LENGTH_BITS = 32;

	typedef logic [LENGTH_BITS-1:0] len_t;

	// byte classes
	localparam logic [2:0] CLS_SEP     = 3'd0;
	localparam logic [2:0] CLS_METHOD  = 3'd1;
	localparam logic [2:0] CLS_URI     = 3'd2;
	localparam logic [2:0] CLS_VERSION = 3'd3;
	localparam logic [2:0] CLS_HNAME   = 3'd4;
	localparam logic [2:0] CLS_HVALUE  = 3'd5;
	localparam logic [2:0] CLS_BODY    = 3'd6;
	localparam logic [2:0] CLS_IGNORED = 3'd7;

	// status codes
	localparam logic [2:0] ST_BUSY      = 3'd0;
	localparam logic [2:0] ST_HEAD_DONE = 3'd1;
	localparam logic [2:0] ST_BODY_DONE = 3'd2;
	localparam logic [2:0] ST_ERROR     = 3'd3;
	localparam logic [2:0] ST_TRAILER   = 3'd4;

	// error codes
	localparam logic [2:0] ERR_NONE      = 3'd0;
	localparam logic [2:0] ERR_SEP       = 3'd1;
	localparam logic [2:0] ERR_CRLF      = 3'd2;
	localparam logic [2:0] ERR_NO_LENGTH = 3'd3;
	localparam logic [2:0] ERR_TRAILER   = 3'd4;

	// method codes
	localparam logic [1:0] METH_UNKNOWN = 2'd0;
	localparam logic [1:0] METH_GET     = 2'd1;
	localparam logic [1:0] METH_POST    = 2'd2;
	localparam logic [1:0] METH_DELETE  = 2'd3;

	// token match flag bits
	localparam int TOK_GET     = 0;
	localparam int TOK_POST    = 1;
	localparam int TOK_DELETE  = 2;
	localparam int TOK_VERSION = 3;
	localparam int TOK_LENGTH  = 4;

	// token lengths
	localparam logic [3:0] LEN_GET     = 4'd3;
	localparam logic [3:0] LEN_POST    = 4'd4;
	localparam logic [3:0] LEN_DELETE  = 4'd6;
	localparam logic [3:0] LEN_VERSION = 4'd8;
	localparam logic [3:0] LEN_LENGTH  = 4'd14;

	// characters
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_ZERO  = 8'h30;

	// one byte as it travels from the front to the back
	typedef struct packed {
		logic       first;
		logic [7:0] data;
		logic [7:0] folded;
		logic       is_letter;
		logic       is_space;
		logic       is_cr;
		logic       is_lf;
		logic       is_colon;
		logic       is_digit;
		logic [3:0] digit;
	} item_t;

	// upper case to lower case, other bytes unchanged
	function automatic logic [7:0] fold_case(input logic [7:0] c);
		logic [7:0] r;
		r = c;
		if (c >= 8'h41 && c <= 8'h5A)
			r = c + 8'd32;
		return r;
	endfunction

	function automatic logic [7:0] get_char(input logic [3:0] i);
		logic [7:0] r;
		case (i)
			4'd0:    r = "G";
			4'd1:    r = "E";
			4'd2:    r = "T";
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] post_char(input logic [3:0] i);
		logic [7:0] r;
		case (i)
			4'd0:    r = "P";
			4'd1:    r = "O";
			4'd2:    r = "S";
			4'd3:    r = "T";
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] delete_char(input logic [3:0] i);
		logic [7:0] r;
		case (i)
			4'd0:    r = "D";
			4'd1:    r = "E";
			4'd2:    r = "L";
			4'd3:    r = "E";
			4'd4:    r = "T";
			4'd5:    r = "E";
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] version_char(input logic [3:0] i);
		logic [7:0] r;
		case (i)
			4'd0:    r = "H";
			4'd1:    r = "T";
			4'd2:    r = "T";
			4'd3:    r = "P";
			4'd4:    r = "/";
			4'd5:    r = "1";
			4'd6:    r = ".";
			4'd7:    r = "1";
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	// content-length, already folded to lower case
	function automatic logic [7:0] length_char(input logic [3:0] i);
		logic [7:0] r;
		case (i)
			4'd0:    r = "c";
			4'd1:    r = "o";
			4'd2:    r = "n";
			4'd3:    r = "t";
			4'd4:    r = "e";
			4'd5:    r = "n";
			4'd6:    r = "t";
			4'd7:    r = "-";
			4'd8:    r = "l";
			4'd9:    r = "e";
			4'd10:   r = "n";
			4'd11:   r = "g";
			4'd12:   r = "t";
			4'd13:   r = "h";
			default: r = 8'h00;
		endcase
		return r;
	endfunction

endpackage

// ----- sv/hrp_front.sv -----
// hrp_front: accepts request bytes and classifies each character
// depends on hrp_pkg; feeds hrp_queue
module hrp_front (
	input  logic          in_valid,
	output logic          in_stall,
	input  logic          first_byte,
	input  logic [7:0]    data_byte,
	input  logic          queue_full,
	output logic          push,
	output hrp_pkg::item_t push_item
);
	import hrp_pkg::*;

	// accept whenever the queue has room
	assign in_stall = queue_full;
	assign push     = in_valid && !queue_full;

	// character classification
	always_comb begin
		push_item.first     = first_byte;
		push_item.data      = data_byte;
		push_item.folded    = fold_case(data_byte);
		push_item.is_letter = (data_byte >= 8'h41 && data_byte <= 8'h5A) ||
			(data_byte >= 8'h61 && data_byte <= 8'h7A);
		push_item.is_space  = (data_byte == CH_SPACE);
		push_item.is_cr     = (data_byte == CH_CR);
		push_item.is_lf     = (data_byte == CH_LF);
		push_item.is_colon  = (data_byte == CH_COLON);
		push_item.is_digit  = (data_byte >= 8'h30 && data_byte <= 8'h39);
		push_item.digit     = 4'(data_byte - CH_ZERO);
	end

endmodule

// ----- sv/hrp_queue.sv -----
// hrp_queue: two-entry queue between the classifier and the parser engine
// depends on hrp_pkg for the item type
module hrp_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  hrp_pkg::item_t push_item,
	output logic           full,
	input  logic           pop,
	output logic           head_valid,
	output hrp_pkg::item_t head_item
);
	import hrp_pkg::*;

	item_t      slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full       = (count_q == 2'd2);
	assign head_valid = (count_q != 2'd0);
	assign head_item  = slot_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (pop)
				rd_ptr_q <= ~rd_ptr_q;
			if (push && !pop)
				count_q <= count_q + 2'd1;
			else if (pop && !push)
				count_q <= count_q - 2'd1;
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_ptr_q] <= push_item;
	end

	a_no_overfill: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd3)
		else $error("queue count out of range");

	a_pop_needs_data: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> count_q != 2'd0)
		else $error("pop from empty queue");

	a_push_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> count_q != 2'd2)
		else $error("push into full queue");

endmodule

// ----- sv/hrp_back.sv -----
// hrp_back: parser engine, one classified byte per cycle unless the output stalls, with output register
// depends on hrp_pkg; drains hrp_queue
module hrp_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           head_valid,
	input  hrp_pkg::item_t head_item,
	output logic           pop,
	output logic           out_valid,
	input  logic           out_stall,
	output logic [2:0]     byte_class,
	output logic [7:0]     echo_byte,
	output logic [2:0]     status,
	output logic [2:0]     error_code,
	output logic [1:0]     method_code,
	output logic           is_version_11,
	output logic [31:0]    body_length,
	output logic [31:0]    body_received
);
	import hrp_pkg::*;

	localparam logic [3:0] PH_METHOD     = 4'd0;
	localparam logic [3:0] PH_URI        = 4'd1;
	localparam logic [3:0] PH_VERSION    = 4'd2;
	localparam logic [3:0] PH_LF_WAIT    = 4'd3;
	localparam logic [3:0] PH_LINE_START = 4'd4;
	localparam logic [3:0] PH_HDR_NAME   = 4'd5;
	localparam logic [3:0] PH_HDR_SPACE  = 4'd6;
	localparam logic [3:0] PH_HDR_VALUE  = 4'd7;
	localparam logic [3:0] PH_BODY       = 4'd8;
	localparam logic [3:0] PH_END        = 4'd9;
	localparam logic [3:0] PH_ERROR      = 4'd10;

	localparam len_t LEN_MAX = '1;

	// parser state
	logic [3:0] phase_q;
	logic [3:0] idx_q;
	logic [4:0] flags_q;
	logic [1:0] method_q;
	logic       version_q;
	logic [1:0] lbc_q;
	logic       seen_q;
	logic       active_q;
	len_t       len_q;
	len_t       body_q;
	logic [2:0] err_q;

	// output register
	logic       out_vld_q;
	logic [2:0] cls_q;
	logic [7:0] echo_q;
	logic [2:0] st_q;
	logic [2:0] oerr_q;
	logic [1:0] ometh_q;
	logic       over_q;
	len_t       olen_q;
	len_t       obody_q;

	// state as seen by this byte, after a possible restart
	logic [3:0] cur_phase;
	logic [3:0] cur_idx;
	logic [4:0] cur_flags;
	logic [1:0] cur_method;
	logic       cur_version;
	logic [1:0] cur_lbc;
	logic       cur_seen;
	logic       cur_active;
	len_t       cur_len;
	len_t       cur_body;
	logic [2:0] cur_err;

	logic [3:0] tok_idx;
	logic [4:0] tok_flags;
	logic [3:0] idx_adv;
	logic [4:0] hit;
	logic [1:0] lbc_inc;
	logic [LENGTH_BITS+3:0] len_mac;
	len_t       len_digit;
	logic [LENGTH_BITS:0] body_inc;

	// next state and result
	logic [3:0] nxt_phase;
	logic [3:0] nxt_idx;
	logic [4:0] nxt_flags;
	logic [1:0] nxt_method;
	logic       nxt_version;
	logic [1:0] nxt_lbc;
	logic       nxt_seen;
	logic       nxt_active;
	len_t       nxt_len;
	len_t       nxt_body;
	logic [2:0] nxt_err;
	logic [2:0] res_cls;
	logic [2:0] res_st;

	logic [LENGTH_BITS+31:0] len_ext;
	logic [LENGTH_BITS+31:0] body_ext;

	// take the next byte whenever the output register frees up
	assign pop = head_valid && (!out_vld_q || !out_stall);

	// restart view
	always_comb begin
		if (head_item.first) begin
			cur_phase   = PH_METHOD;
			cur_idx     = 4'd0;
			cur_flags   = 5'h1F;
			cur_method  = METH_UNKNOWN;
			cur_version = 1'b0;
			cur_lbc     = 2'd0;
			cur_seen    = 1'b0;
			cur_active  = 1'b0;
			cur_len     = '0;
			cur_body    = '0;
			cur_err     = ERR_NONE;
		end else begin
			cur_phase   = phase_q;
			cur_idx     = idx_q;
			cur_flags   = flags_q;
			cur_method  = method_q;
			cur_version = version_q;
			cur_lbc     = lbc_q;
			cur_seen    = seen_q;
			cur_active  = active_q;
			cur_len     = len_q;
			cur_body    = body_q;
			cur_err     = err_q;
		end
	end

	// token compare: a header line starts a fresh token
	always_comb begin
		tok_idx   = (cur_phase == PH_LINE_START) ? 4'd0 : cur_idx;
		tok_flags = (cur_phase == PH_LINE_START) ? 5'h1F : cur_flags;
		idx_adv   = (tok_idx == 4'd15) ? tok_idx : tok_idx + 4'd1;
		hit[TOK_GET]     = (tok_idx < LEN_GET) && (head_item.data == get_char(tok_idx));
		hit[TOK_POST]    = (tok_idx < LEN_POST) && (head_item.data == post_char(tok_idx));
		hit[TOK_DELETE]  = (tok_idx < LEN_DELETE) &&
			(head_item.data == delete_char(tok_idx));
		hit[TOK_VERSION] = (tok_idx < LEN_VERSION) &&
			(head_item.data == version_char(tok_idx));
		hit[TOK_LENGTH]  = (tok_idx < LEN_LENGTH) &&
			(head_item.folded == length_char(tok_idx));
	end

	// arithmetic: times ten plus digit with saturation, body counter
	always_comb begin
		len_mac   = {cur_len, 3'b000} + {2'b00, cur_len, 1'b0} +
			(LENGTH_BITS+4)'(head_item.digit);
		len_digit = (len_mac[LENGTH_BITS+3:LENGTH_BITS] != 4'd0) ? LEN_MAX :
			len_mac[LENGTH_BITS-1:0];
		body_inc  = {1'b0, cur_body} + (LENGTH_BITS+1)'(1);
		lbc_inc   = cur_lbc + 2'd1;
	end

	// phase sequencer
	always_comb begin
		nxt_phase   = cur_phase;
		nxt_idx     = cur_idx;
		nxt_flags   = cur_flags;
		nxt_method  = cur_method;
		nxt_version = cur_version;
		nxt_lbc     = cur_lbc;
		nxt_seen    = cur_seen;
		nxt_active  = cur_active;
		nxt_len     = cur_len;
		nxt_body    = cur_body;
		nxt_err     = cur_err;
		res_cls     = CLS_IGNORED;
		res_st      = ST_BUSY;
		unique case (cur_phase) inside
			PH_METHOD: begin
				if (head_item.is_letter) begin
					nxt_flags = cur_flags & {2'b11, hit[TOK_DELETE:TOK_GET]};
					nxt_idx   = idx_adv;
					res_cls   = CLS_METHOD;
				end else if (head_item.is_space) begin
					if (cur_flags[TOK_GET] && cur_idx == LEN_GET)
						nxt_method = METH_GET;
					else if (cur_flags[TOK_POST] && cur_idx == LEN_POST)
						nxt_method = METH_POST;
					else if (cur_flags[TOK_DELETE] && cur_idx == LEN_DELETE)
						nxt_method = METH_DELETE;
					nxt_phase = PH_URI;
					res_cls   = CLS_SEP;
				end else begin
					nxt_err   = ERR_SEP;
					nxt_phase = PH_ERROR;
					res_st    = ST_ERROR;
				end
			end
			PH_URI: begin
				if (head_item.is_space) begin
					nxt_idx   = 4'd0;
					nxt_flags = 5'h1F;
					nxt_phase = PH_VERSION;
					res_cls   = CLS_SEP;
				end else begin
					res_cls = CLS_URI;
				end
			end
			PH_VERSION: begin
				if (head_item.is_cr) begin
					nxt_version = cur_flags[TOK_VERSION] && (cur_idx == LEN_VERSION);
					nxt_phase   = PH_LF_WAIT;
					res_cls     = CLS_SEP;
				end else begin
					nxt_flags[TOK_VERSION] = cur_flags[TOK_VERSION] & hit[TOK_VERSION];
					nxt_idx = idx_adv;
					res_cls = CLS_VERSION;
				end
			end
			PH_LF_WAIT: begin
				if (head_item.is_lf) begin
					res_cls = CLS_SEP;
					nxt_lbc = lbc_inc;
					if (lbc_inc >= 2'd2) begin
						nxt_body = '0;
						if (!cur_seen) begin
							nxt_err   = ERR_NO_LENGTH;
							nxt_phase = PH_ERROR;
							res_st    = ST_ERROR;
						end else if (cur_len == '0) begin
							nxt_phase = PH_END;
							res_st    = ST_BODY_DONE;
						end else begin
							nxt_phase = PH_BODY;
							res_st    = ST_HEAD_DONE;
						end
					end else begin
						nxt_phase = PH_LINE_START;
					end
				end else begin
					nxt_err   = ERR_CRLF;
					nxt_phase = PH_ERROR;
					res_st    = ST_ERROR;
				end
			end
			PH_LINE_START, PH_HDR_NAME: begin
				if (cur_phase == PH_LINE_START && head_item.is_cr) begin
					nxt_phase = PH_LF_WAIT;
					res_cls   = CLS_SEP;
				end else if (head_item.is_colon) begin
					nxt_idx   = tok_idx;
					nxt_flags = tok_flags;
					if (tok_flags[TOK_LENGTH] && tok_idx == LEN_LENGTH) begin
						nxt_seen   = 1'b1;
						nxt_active = 1'b1;
						nxt_len    = '0;
					end else begin
						nxt_active = 1'b0;
					end
					nxt_phase = PH_HDR_SPACE;
					res_cls   = CLS_SEP;
				end else begin
					nxt_flags = tok_flags;
					nxt_flags[TOK_LENGTH] = tok_flags[TOK_LENGTH] & hit[TOK_LENGTH];
					nxt_idx   = idx_adv;
					nxt_phase = PH_HDR_NAME;
					res_cls   = CLS_HNAME;
				end
			end
			PH_HDR_SPACE, PH_HDR_VALUE: begin
				if (cur_phase == PH_HDR_SPACE && head_item.is_space) begin
					res_cls = CLS_SEP;
				end else if (head_item.is_cr) begin
					nxt_active = 1'b0;
					nxt_lbc    = 2'd0;
					nxt_phase  = PH_LF_WAIT;
					res_cls    = CLS_SEP;
				end else begin
					nxt_phase = PH_HDR_VALUE;
					res_cls   = CLS_HVALUE;
					if (cur_active) begin
						if (head_item.is_digit)
							nxt_len = len_digit;
						else
							nxt_active = 1'b0;
					end
				end
			end
			PH_BODY: begin
				res_cls  = CLS_BODY;
				nxt_body = body_inc[LENGTH_BITS-1:0];
				if (body_inc >= {1'b0, cur_len}) begin
					nxt_phase = PH_END;
					res_st    = ST_BODY_DONE;
				end
			end
			PH_END: begin
				nxt_err = ERR_TRAILER;
				res_st  = ST_TRAILER;
			end
			default: begin
				res_st = ST_ERROR;
			end
		endcase
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_METHOD;
			idx_q     <= 4'd0;
			flags_q   <= 5'h1F;
			method_q  <= METH_UNKNOWN;
			version_q <= 1'b0;
			lbc_q     <= 2'd0;
			seen_q    <= 1'b0;
			active_q  <= 1'b0;
			len_q     <= '0;
			body_q    <= '0;
			err_q     <= ERR_NONE;
			out_vld_q <= 1'b0;
		end else begin
			if (pop) begin
				phase_q   <= nxt_phase;
				idx_q     <= nxt_idx;
				flags_q   <= nxt_flags;
				method_q  <= nxt_method;
				version_q <= nxt_version;
				lbc_q     <= nxt_lbc;
				seen_q    <= nxt_seen;
				active_q  <= nxt_active;
				len_q     <= nxt_len;
				body_q    <= nxt_body;
				err_q     <= nxt_err;
			end
			if (pop)
				out_vld_q <= 1'b1;
			else if (!out_stall)
				out_vld_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (pop) begin
			cls_q   <= res_cls;
			echo_q  <= head_item.data;
			st_q    <= res_st;
			oerr_q  <= nxt_err;
			ometh_q <= nxt_method;
			over_q  <= nxt_version;
			olen_q  <= nxt_len;
			obody_q <= nxt_body;
		end
	end

	// low 32 bits of the length and counter
	assign len_ext  = {32'b0, olen_q};
	assign body_ext = {32'b0, obody_q};

	assign out_valid     = out_vld_q;
	assign byte_class    = cls_q;
	assign echo_byte     = echo_q;
	assign status        = st_q;
	assign error_code    = oerr_q;
	assign method_code   = ometh_q;
	assign is_version_11 = over_q;
	assign body_length   = len_ext[31:0];
	assign body_received = body_ext[31:0];

	a_error_phase_code: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_ERROR |->
			(err_q == ERR_SEP || err_q == ERR_CRLF || err_q == ERR_NO_LENGTH))
		else $error("error phase without a head error code");

	a_body_below_length: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_BODY |-> body_q < len_q)
		else $error("body counter reached length inside body phase");

	a_trailer_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		pop && !head_item.first && phase_q == PH_END |=>
			err_q == ERR_TRAILER && phase_q == PH_END)
		else $error("byte after body did not flag trailer");

	a_held_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && out_stall |-> !pop)
		else $error("output overwritten while stalled");

endmodule

// ----- sv/http_request_head_parser.sv -----
// http_request_head_parser: streaming request head parser, one byte per transfer
// depends on hrp_pkg, hrp_front, hrp_queue and hrp_back
//
// Input channel (in_valid / in_stall) carries one request byte per transfer
// on data_byte; first_byte high restarts parsing with that byte as the first
// byte of a new request. Output channel (out_valid / out_stall) returns one
// result per input byte, in order: the byte's class, the byte itself, a
// status, the sticky error code, the method, the version flag, the parsed
// content length and the number of body bytes seen so far.
// A transferred byte passes through the queue and then the output register
// before its result appears. Throughput is one byte per cycle while the
// receiver does not stall, set by the parser engine; the classifier and
// the engine are parted by a two-entry queue, and the engine's result sits
// in an output register.
// Reset (arst_n low) clears parser state, empties the queue and drops
// out_valid. When the receiver stalls, the result register holds, the queue
// fills with up to two more bytes, and then in_stall rises until the
// receiver takes a result again.
module http_request_head_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        first_byte,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  byte_class,
	output logic [7:0]  echo_byte,
	output logic [2:0]  status,
	output logic [2:0]  error_code,
	output logic [1:0]  method_code,
	output logic        is_version_11,
	output logic [31:0] body_length,
	output logic [31:0] body_received
);
	import hrp_pkg::*;

	logic  push;
	item_t push_item;
	logic  queue_full;
	logic  pop;
	logic  head_valid;
	item_t head_item;

	// classifier
	hrp_front u_front (
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.first_byte (first_byte),
		.data_byte  (data_byte),
		.queue_full (queue_full),
		.push       (push),
		.push_item  (push_item)
	);

	// decoupling queue
	hrp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_item  (push_item),
		.full       (queue_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_item  (head_item)
	);

	// parser engine
	hrp_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head_valid    (head_valid),
		.head_item     (head_item),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.byte_class    (byte_class),
		.echo_byte     (echo_byte),
		.status        (status),
		.error_code    (error_code),
		.method_code   (method_code),
		.is_version_11 (is_version_11),
		.body_length   (body_length),
		.body_received (body_received)
	);

endmodule
